/* rtl/core/bmw_pkg.sv */
`default_nettype none

package bmw_pkg;

  // Field and register widths fixed by the interface.
  localparam int FRAME_BITS     = 11;
  localparam int PIX_BITS       = 8;
  localparam int HALF_CFG_BITS  = 3;
  localparam int CFG_DATA_BITS  = 11;
  localparam int CFG_INDEX_BITS = 3;

  // Default sizes for the top level parameters.
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_MAX_HALF  = 7;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCALE        = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HALF_WIDTH   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HALF_HEIGHT  = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OPERATION    = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COLOR        = 3'd6;

  // Input item kinds.
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  // Morphology operations.
  typedef enum logic [1:0] {
    OP_DILATE = 2'd0,
    OP_ERODE  = 2'd1,
    OP_OPEN   = 2'd2,
    OP_CLOSE  = 2'd3
  } op_t;

  // Register reset values.
  localparam logic [FRAME_BITS-1:0]    RST_FRAME_WIDTH  = 11'd1024;
  localparam logic [FRAME_BITS-1:0]    RST_FRAME_HEIGHT = 11'd1024;
  localparam logic [PIX_BITS-1:0]      RST_SCALE        = 8'd255;
  localparam logic [HALF_CFG_BITS-1:0] RST_HALF         = 3'd1;

endpackage

`default_nettype wire

/* rtl/core/bmw_stage.sv */
`default_nettype none

module bmw_stage #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HALF  = 7
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_step,
  input  wire logic                           in_bit,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]   in_col,
  input  wire logic                           in_border,
  input  wire logic [$clog2(MAX_HALF+1)-1:0]  in_hw,
  input  wire logic [$clog2(MAX_HALF+1)-1:0]  in_hh,
  input  wire logic                           in_erode,
  output logic                                res_valid,
  output logic                                res_bit
);

  localparam int COL_BITS  = $clog2(MAX_WIDTH);
  localparam int HALF_BITS = $clog2(MAX_HALF + 1);
  localparam int LS_BITS   = 2 * MAX_HALF;
  localparam int CV_BITS   = LS_BITS + 1;
  localparam int NCELL     = 2 * MAX_HALF + 1;

  // Line store: per column, the bits of the previous rows, newest in bit 0.
  logic [LS_BITS-1:0]   mem [MAX_WIDTH];
  logic [LS_BITS-1:0]   rd;
  logic                 step_d;
  logic                 bit_d;
  logic [COL_BITS-1:0]  col_d;
  logic                 border_d;
  logic [HALF_BITS-1:0] hw_d;
  logic [HALF_BITS-1:0] hh_d;
  logic                 erode_d;

  // Window cells: cell 0 holds the newest column vector.
  logic [CV_BITS-1:0]   cells [NCELL];
  logic                 step_q;
  logic                 border_q;
  logic [HALF_BITS-1:0] hw_q;
  logic [HALF_BITS-1:0] hh_q;
  logic                 erode_q;

  logic [LS_BITS-1:0]   wr_data;
  logic                 any_set;
  logic                 all_set;

  assign wr_data = {rd[LS_BITS-2:0], bit_d};

  // Line store read with bypass of the write in flight to the same column.
  always_ff @(posedge clk) begin
    if (step_d) begin
      mem[col_d] <= wr_data;
    end
    if (in_step) begin
      if (step_d && (col_d == in_col)) begin
        rd <= wr_data;
      end else begin
        rd <= mem[in_col];
      end
    end
  end

  // Item payload is registered in step with the read and the window cells.
  always_ff @(posedge clk) begin
    bit_d    <= in_bit;
    col_d    <= in_col;
    border_d <= in_border;
    hw_d     <= in_hw;
    hh_d     <= in_hh;
    erode_d  <= in_erode;
    border_q <= border_d;
    hw_q     <= hw_d;
    hh_q     <= hh_d;
    erode_q  <= erode_d;
  end

  // Each cell hands its column to the neighbor when a new column arrives.
  always_ff @(posedge clk) begin
    if (step_d) begin
      cells[0] <= {rd, bit_d};
      for (int j = 1; j < NCELL; j++) begin
        cells[j] <= cells[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_d <= 1'b0;
      step_q <= 1'b0;
    end else begin
      step_d <= in_step;
      step_q <= step_d;
    end
  end

  // Reduce the bits inside the active window rectangle.
  always_comb begin
    any_set = 1'b0;
    all_set = 1'b1;
    for (int j = 0; j < NCELL; j++) begin
      for (int i = 0; i < CV_BITS; i++) begin
        if (((HALF_BITS+1)'(i) <= {hh_q, 1'b0}) && ((HALF_BITS+1)'(j) <= {hw_q, 1'b0})) begin
          any_set = any_set | cells[j][i];
          all_set = all_set & cells[j][i];
        end
      end
    end
  end

  assign res_valid = step_q;
  assign res_bit   = !border_q && (erode_q ? all_set : any_set);

endmodule

`default_nettype wire

/* rtl/core/binary_morphology_window_top.sv */
// Binary dilation, erosion, opening and closing over a raster pixel stream.
// Throughput: one item per cycle while in_ready is high; each accepted item
// passes the token registers tk1 to tk4, beside the line stores and window
// cells, before its result is written to the output queue, and out_valid
// rises with that write. A result appears D positions after its pixel for
// one window stage and 2D positions for two, where D =
// half_height * width + half_width; passthrough has no delay. Reset (synchronous)
// clears counters and queue, loads register defaults; line stores and cells stay unset.
`default_nettype none

module binary_morphology_window_top
  import bmw_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_HALF  = DEF_MAX_HALF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      kind,
  input  wire logic [PIX_BITS-1:0]       pixel,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [PIX_BITS-1:0]            result_pixel,
  output logic                           last,
  input  wire logic                      cfg_write_en,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int WBITS      = $clog2(MAX_WIDTH + 1);
  localparam int HALF_BITS  = $clog2(MAX_HALF + 1);
  localparam int ROW_BITS   = FRAME_BITS;
  localparam int TICK_BITS  =
      $clog2(MAX_WIDTH * 2048 + 2 * (MAX_HALF * MAX_WIDTH + MAX_HALF) + 2);
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_ABITS = $clog2(FIFO_DEPTH);
  localparam int RST_W      = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam logic [TICK_BITS-1:0] RST_D1 = TICK_BITS'(RST_W + 1);

  typedef struct packed {
    logic                 valid;
    logic                 pass;
    logic                 have;
    logic                 last;
    logic                 st2;
    op_t                  op;
    logic [PIX_BITS-1:0]  scale;
    logic [PIX_BITS-1:0]  pix;
    logic [HALF_BITS-1:0] hw;
    logic [HALF_BITS-1:0] hh;
    logic                 border2;
    logic [COL_BITS-1:0]  col2;
    logic                 res1;
  } token_t;

  // Configuration registers as written.
  logic [FRAME_BITS-1:0]    cfg_w;
  logic [FRAME_BITS-1:0]    cfg_h;
  logic [PIX_BITS-1:0]      cfg_scale;
  logic [HALF_CFG_BITS-1:0] cfg_hw;
  logic [HALF_CFG_BITS-1:0] cfg_hh;
  op_t                      cfg_op;
  logic                     cfg_color;
  logic [TICK_BITS-1:0]     cfg_d1;

  // Settings latched for the frame in progress.
  logic [WBITS-1:0]         act_w;
  logic [ROW_BITS-1:0]      act_h;
  logic [PIX_BITS-1:0]      act_scale;
  logic [HALF_BITS-1:0]     act_hw;
  logic [HALF_BITS-1:0]     act_hh;
  op_t                      act_op;
  logic                     act_color;
  logic [TICK_BITS-1:0]     act_d1;

  // Clamped register values and the values in force for this item.
  logic [WBITS-1:0]         clw;
  logic [ROW_BITS-1:0]      clh;
  logic [HALF_BITS-1:0]     clhw;
  logic [HALF_BITS-1:0]     clhh;
  logic [WBITS-1:0]         eff_w;
  logic [ROW_BITS-1:0]      eff_h;
  logic [PIX_BITS-1:0]      eff_scale;
  logic [HALF_BITS-1:0]     eff_hw;
  logic [HALF_BITS-1:0]     eff_hh;
  op_t                      eff_op;
  logic                     eff_color;
  logic [TICK_BITS-1:0]     eff_d1;

  // Frame position counters.
  logic [TICK_BITS-1:0]     tick;
  logic [COL_BITS-1:0]      in_col;
  logic [ROW_BITS-1:0]      in_row;
  logic [COL_BITS-1:0]      pos_col;
  logic [COL_BITS-1:0]      c1_col;
  logic [ROW_BITS-1:0]      c1_row;
  logic [COL_BITS-1:0]      c2_col;
  logic [ROW_BITS-1:0]      c2_row;
  logic [COL_BITS-1:0]      o_col;
  logic [ROW_BITS-1:0]      o_row;

  logic                     acc;
  logic                     at_start;
  logic                     pix_ok;
  logic                     drain_ok;
  logic                     do_pass;
  logic                     do_step;
  logic                     in_bit;
  logic                     ge1;
  logic                     ge2;
  logic                     two_stage;
  logic                     have;
  logic                     st2;
  logic                     last_pass;
  logic                     last_emit;
  logic                     frame_end;
  logic                     border1;
  logic                     border2;

  token_t                   tk1, tk2, tk3, tk4;
  logic                     s1_valid, s1_bit, s2_valid, s2_bit;

  logic [PIX_BITS:0]        fifo [FIFO_DEPTH];
  logic [FIFO_ABITS-1:0]    head, tail;
  logic [FIFO_ABITS:0]      count;
  logic [FIFO_ABITS:0]      pending;
  logic                     push, pop, drop;
  logic                     res_set;
  logic [PIX_BITS-1:0]      push_pix;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w     <= RST_FRAME_WIDTH;
      cfg_h     <= RST_FRAME_HEIGHT;
      cfg_scale <= RST_SCALE;
      cfg_hw    <= RST_HALF;
      cfg_hh    <= RST_HALF;
      cfg_op    <= OP_DILATE;
      cfg_color <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        unique case (cfg_index)
          REG_FRAME_WIDTH:  cfg_w     <= cfg_data;
          REG_FRAME_HEIGHT: cfg_h     <= cfg_data;
          REG_SCALE:        cfg_scale <= cfg_data[PIX_BITS-1:0];
          REG_HALF_WIDTH:   cfg_hw    <= cfg_data[HALF_CFG_BITS-1:0];
          REG_HALF_HEIGHT:  cfg_hh    <= cfg_data[HALF_CFG_BITS-1:0];
          REG_OPERATION:    cfg_op    <= op_t'(cfg_data[1:0]);
          REG_COLOR:        cfg_color <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // Zero frame sizes act as one; oversize width and half sizes are clamped.
  always_comb begin
    if (cfg_w == '0) begin
      clw = WBITS'(1);
    end else if (32'(cfg_w) > 32'(MAX_WIDTH)) begin
      clw = WBITS'(MAX_WIDTH);
    end else begin
      clw = WBITS'(cfg_w);
    end
    clh  = (cfg_h == '0) ? ROW_BITS'(1) : cfg_h;
    clhw = (32'(cfg_hw) > 32'(MAX_HALF)) ? HALF_BITS'(MAX_HALF) : HALF_BITS'(cfg_hw);
    clhh = (32'(cfg_hh) > 32'(MAX_HALF)) ? HALF_BITS'(MAX_HALF) : HALF_BITS'(cfg_hh);
  end

  // Window delay in raster positions for the current register values.
  assign cfg_d1 = TICK_BITS'(clhh) * TICK_BITS'(clw) + TICK_BITS'(clhw);

  // The first pixel of a frame uses the registers directly.
  assign at_start  = (tick == '0);
  assign eff_w     = at_start ? clw : act_w;
  assign eff_h     = at_start ? clh : act_h;
  assign eff_scale = at_start ? cfg_scale : act_scale;
  assign eff_hw    = at_start ? clhw : act_hw;
  assign eff_hh    = at_start ? clhh : act_hh;
  assign eff_op    = at_start ? cfg_op : act_op;
  assign eff_color = at_start ? cfg_color : act_color;
  assign eff_d1    = at_start ? cfg_d1 : act_d1;

  // Item classification.
  assign acc       = in_valid && in_ready;
  assign pix_ok    = (kind == KIND_PIXEL) && (in_row < eff_h);
  assign drain_ok  = (kind == KIND_DRAIN) && !at_start && (in_row >= act_h);
  assign do_pass   = acc && pix_ok && eff_color;
  assign do_step   = acc && ((pix_ok && !eff_color) || drain_ok);
  assign in_bit    = (kind == KIND_PIXEL) && (pixel == eff_scale);
  assign ge1       = tick >= eff_d1;
  assign ge2       = (TICK_BITS+1)'(tick) >= {eff_d1, 1'b0};
  assign two_stage = (eff_op == OP_OPEN) || (eff_op == OP_CLOSE);
  assign have      = two_stage ? ge2 : ge1;
  assign st2       = two_stage && ge1;
  assign last_pass = (WBITS'(in_col) + WBITS'(1) == eff_w) &&
                     (in_row + ROW_BITS'(1) == eff_h);
  assign last_emit = (WBITS'(o_col) + WBITS'(1) == eff_w) &&
                     (o_row + ROW_BITS'(1) == eff_h);
  assign frame_end = (do_pass && last_pass) || (do_step && have && last_emit);

  // Edge test for the window centers of both stages.
  assign border1 = (c1_row < ROW_BITS'(eff_hh)) ||
                   ((ROW_BITS+1)'(c1_row) + (ROW_BITS+1)'(eff_hh) >= (ROW_BITS+1)'(eff_h)) ||
                   (c1_col < COL_BITS'(eff_hw)) ||
                   ((WBITS+1)'(c1_col) + (WBITS+1)'(eff_hw) >= (WBITS+1)'(eff_w));
  assign border2 = (c2_row < ROW_BITS'(eff_hh)) ||
                   ((ROW_BITS+1)'(c2_row) + (ROW_BITS+1)'(eff_hh) >= (ROW_BITS+1)'(eff_h)) ||
                   (c2_col < COL_BITS'(eff_hw)) ||
                   ((WBITS+1)'(c2_col) + (WBITS+1)'(eff_hw) >= (WBITS+1)'(eff_w));

  // Frame latch and position counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      act_w     <= WBITS'(RST_W);
      act_h     <= RST_FRAME_HEIGHT;
      act_scale <= RST_SCALE;
      act_hw    <= HALF_BITS'(1);
      act_hh    <= HALF_BITS'(1);
      act_op    <= OP_DILATE;
      act_color <= 1'b0;
      act_d1    <= RST_D1;
      tick      <= '0;
      in_col    <= '0;
      in_row    <= '0;
      pos_col   <= '0;
      c1_col    <= '0;
      c1_row    <= '0;
      c2_col    <= '0;
      c2_row    <= '0;
      o_col     <= '0;
      o_row     <= '0;
    end else begin
      if (acc && at_start && (kind == KIND_PIXEL)) begin
        act_w     <= clw;
        act_h     <= clh;
        act_scale <= cfg_scale;
        act_hw    <= clhw;
        act_hh    <= clhh;
        act_op    <= cfg_op;
        act_color <= cfg_color;
        act_d1    <= cfg_d1;
      end
      if (frame_end) begin
        tick    <= '0;
        in_col  <= '0;
        in_row  <= '0;
        pos_col <= '0;
        c1_col  <= '0;
        c1_row  <= '0;
        c2_col  <= '0;
        c2_row  <= '0;
        o_col   <= '0;
        o_row   <= '0;
      end else begin
        if (do_pass || do_step) begin
          tick <= tick + TICK_BITS'(1);
        end
        if (do_pass || (do_step && (kind == KIND_PIXEL))) begin
          if (WBITS'(in_col) + WBITS'(1) == eff_w) begin
            in_col <= '0;
            in_row <= in_row + ROW_BITS'(1);
          end else begin
            in_col <= in_col + COL_BITS'(1);
          end
        end
        if (do_step) begin
          pos_col <= (WBITS'(pos_col) + WBITS'(1) == eff_w) ? '0 : pos_col + COL_BITS'(1);
        end
        if (do_step && ge1) begin
          if (WBITS'(c1_col) + WBITS'(1) == eff_w) begin
            c1_col <= '0;
            c1_row <= c1_row + ROW_BITS'(1);
          end else begin
            c1_col <= c1_col + COL_BITS'(1);
          end
        end
        if (do_step && two_stage && ge2) begin
          if (WBITS'(c2_col) + WBITS'(1) == eff_w) begin
            c2_col <= '0;
            c2_row <= c2_row + ROW_BITS'(1);
          end else begin
            c2_col <= c2_col + COL_BITS'(1);
          end
        end
        if (do_step && have) begin
          if (WBITS'(o_col) + WBITS'(1) == eff_w) begin
            o_col <= '0;
            o_row <= o_row + ROW_BITS'(1);
          end else begin
            o_col <= o_col + COL_BITS'(1);
          end
        end
      end
    end
  end

  // First window stage takes every stepping item.
  bmw_stage #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HALF  (MAX_HALF)
  ) u_stage1 (
    .clk       (clk),
    .rst       (rst),
    .in_step   (do_step),
    .in_bit    (in_bit),
    .in_col    (pos_col),
    .in_border (border1),
    .in_hw     (eff_hw),
    .in_hh     (eff_hh),
    .in_erode  ((eff_op == OP_ERODE) || (eff_op == OP_OPEN)),
    .res_valid (s1_valid),
    .res_bit   (s1_bit)
  );

  // Second window stage takes first stage results for open and close.
  bmw_stage #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HALF  (MAX_HALF)
  ) u_stage2 (
    .clk       (clk),
    .rst       (rst),
    .in_step   (tk2.valid && tk2.st2),
    .in_bit    (s1_bit),
    .in_col    (tk2.col2),
    .in_border (tk2.border2),
    .in_hw     (tk2.hw),
    .in_hh     (tk2.hh),
    .in_erode  (tk2.op == OP_CLOSE),
    .res_valid (s2_valid),
    .res_bit   (s2_bit)
  );

  // Item tokens travel beside the stages so every result has the same latency.
  always_ff @(posedge clk) begin
    if (rst) begin
      tk1.valid <= 1'b0;
      tk2.valid <= 1'b0;
      tk3.valid <= 1'b0;
      tk4.valid <= 1'b0;
    end else begin
      tk1.valid <= do_pass || do_step;
      tk2.valid <= tk1.valid;
      tk3.valid <= tk2.valid;
      tk4.valid <= tk3.valid;
    end
    tk1.pass    <= do_pass;
    tk1.have    <= do_pass || have;
    tk1.last    <= do_pass ? last_pass : last_emit;
    tk1.st2     <= st2;
    tk1.op      <= eff_op;
    tk1.scale   <= eff_scale;
    tk1.pix     <= pixel;
    tk1.hw      <= eff_hw;
    tk1.hh      <= eff_hh;
    tk1.border2 <= border2;
    tk1.col2    <= c1_col;
    tk1.res1    <= 1'b0;
    tk2[$bits(token_t)-2:0] <= tk1[$bits(token_t)-2:0];
    tk3[$bits(token_t)-2:0] <= {tk2[$bits(token_t)-2:1], s1_bit};
    tk4[$bits(token_t)-2:0] <= tk3[$bits(token_t)-2:0];
  end

  // Final result value.
  assign res_set  = ((tk4.op == OP_OPEN) || (tk4.op == OP_CLOSE)) ? s2_bit : tk4.res1;
  assign push_pix = tk4.pass ? tk4.pix : (res_set ? tk4.scale : '0);
  assign push     = tk4.valid && tk4.have;
  assign drop     = tk4.valid && !tk4.have;
  assign pop      = out_valid && out_ready;

  // Output queue; credits cover items still inside the stages.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[tail] <= {tk4.last, push_pix};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      tail    <= '0;
      count   <= '0;
      pending <= '0;
    end else begin
      if (push) begin
        tail <= tail + FIFO_ABITS'(1);
      end
      if (pop) begin
        head <= head + FIFO_ABITS'(1);
      end
      count   <= count + (FIFO_ABITS+1)'(push) - (FIFO_ABITS+1)'(pop);
      pending <= pending + (FIFO_ABITS+1)'(do_pass || do_step)
                 - (FIFO_ABITS+1)'(pop) - (FIFO_ABITS+1)'(drop);
    end
  end

  assign in_ready     = pending < (FIFO_ABITS+1)'(FIFO_DEPTH);
  assign out_valid    = (count != '0);
  assign result_pixel = fifo[head][PIX_BITS-1:0];
  assign last         = fifo[head][PIX_BITS];

  // Credits never exceed the queue depth, so a push always finds room.
  assert property (@(posedge clk) disable iff (rst)
    pending <= (FIFO_ABITS+1)'(FIFO_DEPTH))
    else $error("credit count exceeds queue depth");

  // Items in the queue are always covered by credits.
  assert property (@(posedge clk) disable iff (rst) count <= pending)
    else $error("queue holds more items than credits");

  // The first stage result lines up with its token.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid == (tk2.valid && !tk2.pass))
    else $error("first stage out of step with token pipe");

  // The second stage result lines up with a token that asked for it.
  assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (tk4.valid && tk4.st2))
    else $error("second stage out of step with token pipe");

endmodule

`default_nettype wire
